>>> hw/rtl/uartt_pkg.sv
package uartt_pkg;

  localparam int unsigned DataBitsDefault = 8;
  localparam int unsigned ByteW           = 8;
  localparam int unsigned CountW          = 4;
  localparam int unsigned TimerW          = 16;
  localparam int unsigned CfgIdxW         = 1;
  localparam int unsigned CfgDataW        = 16;

  localparam logic [TimerW-1:0] BitPeriodReset  = 16'd104;
  localparam logic [TimerW-1:0] HalfPeriodReset = 16'd52;

  localparam logic [CfgIdxW-1:0] CfgBitPeriod  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgHalfPeriod = 1'b1;

  typedef enum logic [3:0] {
    PhIdle  = 4'b0001,
    PhStart = 4'b0010,
    PhData  = 4'b0100,
    PhStop  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic line;
    logic busy;
  } tx_res_t;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
    logic             glitch;
  } rx_res_t;

endpackage

>>> hw/rtl/uart_transceiver_8n1.sv
// UART transceiver, 8N1 framing, one input word per serial time tick.
// Input channel (in_valid_i / in_stall_o): each word carries the sampled
// receive line, a send request and the byte to send. Output channel
// (out_valid_o / out_stall_i): one word per input word with the transmit
// line level, transmitter busy flag and receiver status for that tick.
// A word is taken on a rising edge with valid high and stall low.
// The result of a tick is registered and appears in the cycle after it is accepted.
// Throughput: one tick per clock while the input is not stalled; transmitter
// and receiver state advance once per accepted tick, using the 16-bit timer
// decrement and compare in each direction.
// The output register holds its word while out_stall_i is high; the input
// stalls only when that register is full and still stalled, so a word is
// taken in the same cycle the held result leaves.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_index_i
// (0: ticks per bit cell, 1: ticks to start-bit confirmation). Write only
// while idle. Reset returns both sides to idle, the periods to 104 and 52
// and empties the output register.
module uart_transceiver_8n1 #(
  parameter int unsigned DATA_BITS = uartt_pkg::DataBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           rx_line_i,
  input  logic                           send_request_i,
  input  logic [uartt_pkg::ByteW-1:0]    send_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           tx_line_o,
  output logic                           tx_busy_o,
  output logic                           rx_valid_o,
  output logic [uartt_pkg::ByteW-1:0]    rx_byte_o,
  output logic                           rx_glitch_o,
  input  logic                           cfg_we_i,
  input  logic [uartt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [uartt_pkg::CfgDataW-1:0] cfg_wdata_i
);

  logic [uartt_pkg::TimerW-1:0] bit_period_q, half_period_q;
  logic                         accept;
  logic                         out_valid_q, out_valid_d;
  uartt_pkg::tx_res_t           tx_res, tx_res_q;
  uartt_pkg::rx_res_t           rx_res, rx_res_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q  <= uartt_pkg::BitPeriodReset;
      half_period_q <= uartt_pkg::HalfPeriodReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        uartt_pkg::CfgBitPeriod:  bit_period_q  <= uartt_pkg::TimerW'(cfg_wdata_i);
        uartt_pkg::CfgHalfPeriod: half_period_q <= uartt_pkg::TimerW'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  uartt_tx #(.DATA_BITS(DATA_BITS)) u_tx (
    .clk_i,
    .rst_ni,
    .adv_i          (accept),
    .send_request_i,
    .send_byte_i,
    .bit_period_i   (bit_period_q),
    .res_o          (tx_res)
  );

  uartt_rx #(.DATA_BITS(DATA_BITS)) u_rx (
    .clk_i,
    .rst_ni,
    .adv_i         (accept),
    .rx_line_i,
    .bit_period_i  (bit_period_q),
    .half_period_i (half_period_q),
    .res_o         (rx_res)
  );

  assign out_valid_d = accept || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tx_res_q <= tx_res;
      rx_res_q <= rx_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign tx_line_o   = tx_res_q.line;
  assign tx_busy_o   = tx_res_q.busy;
  assign rx_valid_o  = rx_res_q.valid;
  assign rx_byte_o   = rx_res_q.data;
  assign rx_glitch_o = rx_res_q.glitch;

endmodule

>>> hw/rtl/uartt_tx.sv
module uartt_tx #(
  parameter int unsigned DATA_BITS = uartt_pkg::DataBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          send_request_i,
  input  logic [uartt_pkg::ByteW-1:0]   send_byte_i,
  input  logic [uartt_pkg::TimerW-1:0]  bit_period_i,
  output uartt_pkg::tx_res_t            res_o
);

  uartt_pkg::phase_e                  phase_q, phase_d, phase_e_w;
  logic [uartt_pkg::ByteW-1:0]        shift_q, shift_d, shift_e;
  logic [uartt_pkg::CountW-1:0]       bits_q, bits_d, bits_e;
  logic [uartt_pkg::TimerW-1:0]       timer_q, timer_d, timer_e;
  logic                               expired;
  logic                               start;

  assign start   = (phase_q == uartt_pkg::PhIdle) && send_request_i;
  assign expired = (timer_e <= uartt_pkg::TimerW'(1));

  always_comb begin
    // a request on an idle tick takes effect on that same tick
    phase_e_w = start ? uartt_pkg::PhStart : phase_q;
    shift_e   = start ? send_byte_i : shift_q;
    bits_e    = start ? '0 : bits_q;
    timer_e   = start ? bit_period_i : timer_q;

    phase_d   = phase_e_w;
    shift_d   = shift_e;
    bits_d    = bits_e;
    timer_d   = timer_e - uartt_pkg::TimerW'(1);
    res_o.line = 1'b1;
    res_o.busy = (phase_e_w != uartt_pkg::PhIdle);

    unique case (phase_e_w)
      uartt_pkg::PhStart: begin
        res_o.line = 1'b0;
        if (expired) begin
          phase_d = uartt_pkg::PhData;
          bits_d  = uartt_pkg::CountW'(DATA_BITS);
          timer_d = bit_period_i;
        end
      end
      uartt_pkg::PhData: begin
        res_o.line = shift_e[0];
        if (expired) begin
          shift_d = shift_e >> 1;
          bits_d  = bits_e - uartt_pkg::CountW'(1);
          timer_d = bit_period_i;
          if (bits_d == '0) phase_d = uartt_pkg::PhStop;
        end
      end
      uartt_pkg::PhStop: begin
        if (expired) phase_d = uartt_pkg::PhIdle;
      end
      default: begin
        timer_d = timer_e;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= uartt_pkg::PhIdle;
      shift_q <= '0;
      bits_q  <= '0;
      timer_q <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      bits_q  <= bits_d;
      timer_q <= timer_d;
    end
  end

endmodule

>>> hw/rtl/uartt_rx.sv
module uartt_rx #(
  parameter int unsigned DATA_BITS = uartt_pkg::DataBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          rx_line_i,
  input  logic [uartt_pkg::TimerW-1:0]  bit_period_i,
  input  logic [uartt_pkg::TimerW-1:0]  half_period_i,
  output uartt_pkg::rx_res_t            res_o
);

  uartt_pkg::phase_e                  phase_q, phase_d;
  logic [uartt_pkg::ByteW-1:0]        shift_q, shift_d;
  logic [uartt_pkg::CountW-1:0]       bits_q, bits_d;
  logic [uartt_pkg::TimerW-1:0]       timer_q, timer_d;
  logic [uartt_pkg::CountW-1:0]       pos;
  logic                               expired;

  assign expired = (timer_q <= uartt_pkg::TimerW'(1));
  assign pos     = uartt_pkg::CountW'(DATA_BITS) - bits_q;

  always_comb begin
    phase_d      = phase_q;
    shift_d      = shift_q;
    bits_d       = bits_q;
    timer_d      = timer_q - uartt_pkg::TimerW'(1);
    res_o.valid  = 1'b0;
    res_o.data   = '0;
    res_o.glitch = 1'b0;

    unique case (phase_q)
      uartt_pkg::PhIdle: begin
        timer_d = timer_q;
        if (!rx_line_i) begin
          phase_d = uartt_pkg::PhStart;
          timer_d = half_period_i;
        end
      end
      uartt_pkg::PhStart: begin
        if (expired) begin
          if (rx_line_i) begin
            // line back high by mid start bit: drop it as noise
            res_o.glitch = 1'b1;
            phase_d      = uartt_pkg::PhIdle;
          end else begin
            phase_d = uartt_pkg::PhData;
            shift_d = '0;
            bits_d  = uartt_pkg::CountW'(DATA_BITS);
            timer_d = bit_period_i;
          end
        end
      end
      uartt_pkg::PhData: begin
        if (expired) begin
          // bits past the eighth are dropped
          if (pos < uartt_pkg::CountW'(uartt_pkg::ByteW) && rx_line_i) begin
            shift_d[pos[2:0]] = 1'b1;
          end
          bits_d  = bits_q - uartt_pkg::CountW'(1);
          timer_d = bit_period_i;
          if (bits_d == '0) phase_d = uartt_pkg::PhStop;
        end
      end
      uartt_pkg::PhStop: begin
        if (expired) begin
          res_o.valid = 1'b1;
          res_o.data  = shift_q;
          phase_d     = uartt_pkg::PhIdle;
        end
      end
      default: begin
        phase_d = uartt_pkg::PhIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= uartt_pkg::PhIdle;
      shift_q <= '0;
      bits_q  <= '0;
      timer_q <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      bits_q  <= bits_d;
      timer_q <= timer_d;
    end
  end

endmodule

>>> hw/rtl/uartt_checker.sv
module uartt_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic                           tx_line_o,
  input logic                           tx_busy_o,
  input logic                           rx_valid_o,
  input logic [uartt_pkg::ByteW-1:0]    rx_byte_o,
  input logic                           rx_glitch_o
);

  // stall only while a result is held back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // every accepted tick yields a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted tick produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(rx_valid_o && rx_glitch_o))
    else $error("byte and glitch reported together");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !rx_valid_o) |-> (rx_byte_o == '0))
    else $error("received byte not cleared without valid");

  // an idle transmitter drives the line high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !tx_busy_o) |-> tx_line_o)
    else $error("transmit line low while idle");

endmodule

bind uart_transceiver_8n1 uartt_checker u_checker (.*);
